// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define AIP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define AIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/aip_pkg.sv =====
// Package with the types, character codes and helpers of the ASCII integer parser.
package aip_pkg;

   localparam int RESULT_WIDTH_DEFAULT = 32;
   localparam int CHAR_WIDTH           = 8;
   localparam int DIGIT_WIDTH          = 4;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UA    = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UF    = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UX    = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LA    = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LF    = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LX    = 8'h78;
   localparam logic [DIGIT_WIDTH-1:0] HEX_LETTER_BASE = 4'd10;

   typedef enum logic [5:0] {
      PH_SPACE  = 6'b000001,
      PH_SIGNED = 6'b000010,
      PH_ZERO   = 6'b000100,
      PH_DEC    = 6'b001000,
      PH_HEX    = 6'b010000,
      PH_STOP   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic                  valid;
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  end_of_string;
   } item_type;

   typedef struct packed {
      logic ok;
      logic [DIGIT_WIDTH-1:0] value;
   } digit_type;

   function automatic logic is_blank(input logic [CHAR_WIDTH-1:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic digit_type dec_digit(input logic [CHAR_WIDTH-1:0] c);
      digit_type d;
      d.ok    = (c >= CHAR_0) && (c <= CHAR_9);
      d.value = c[DIGIT_WIDTH-1:0];
      return d;
   endfunction

   function automatic digit_type hex_digit(input logic [CHAR_WIDTH-1:0] c);
      digit_type d;
      d.ok    = 1'b1;
      d.value = c[DIGIT_WIDTH-1:0];
      if ((c >= CHAR_0) && (c <= CHAR_9)) begin
         d.value = c[DIGIT_WIDTH-1:0];
      end else if ((c >= CHAR_LA) && (c <= CHAR_LF)) begin
         d.value = DIGIT_WIDTH'(c - CHAR_LA) + HEX_LETTER_BASE;
      end else if ((c >= CHAR_UA) && (c <= CHAR_UF)) begin
         d.value = DIGIT_WIDTH'(c - CHAR_UA) + HEX_LETTER_BASE;
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

endpackage

// ===== hdl/aip_input_stage.sv =====
// Input register that holds one word of the request channel until the parser takes it.
module aip_input_stage
   import aip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_WIDTH-1:0] req_char_code,
   input  logic                  req_end_of_string,
   input  logic                  advance,
   output item_type              item
);

   logic                  valid_ff;
   logic [CHAR_WIDTH-1:0] char_ff;
   logic                  eos_ff;
   logic                  load;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= req_char_code;
         eos_ff  <= req_end_of_string;
      end
   end

   assign item.valid         = valid_ff;
   assign item.char_code     = char_ff;
   assign item.end_of_string = eos_ff;

endmodule

// ===== hdl/aip_core.sv =====
// Parser state machine, accumulator and sign, updated once for each word.
`include "assert_macros.svh"
module aip_core
   import aip_pkg::*;
#(
   parameter int RESULT_WIDTH = RESULT_WIDTH_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  item_type                item,
   input  logic                    advance,
   output logic                    result_valid,
   output logic [RESULT_WIDTH-1:0] result_value
);

   phase_type               phase_ff, phase_in;
   logic [RESULT_WIDTH-1:0] acc_ff, acc_in;
   logic                    neg_ff, neg_in;
   logic [RESULT_WIDTH-1:0] acc_x10, acc_x16;
   digit_type               dd, hd;
   logic                    take;
   logic [CHAR_WIDTH-1:0]   c;

   assign c       = item.char_code;
   assign dd      = dec_digit(c);
   assign hd      = hex_digit(c);
   assign acc_x10 = (acc_ff << 3) + (acc_ff << 1)
                    + {{(RESULT_WIDTH-DIGIT_WIDTH){1'b0}}, dd.value};
   assign acc_x16 = {acc_ff[RESULT_WIDTH-DIGIT_WIDTH-1:0], hd.value};
   assign take    = item.valid && advance;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      unique case (phase_ff)
         PH_SPACE, PH_SIGNED: begin
            if ((phase_ff == PH_SPACE) && is_blank(c)) begin
               phase_in = PH_SPACE;
            end else if ((phase_ff == PH_SPACE) && ((c == CHAR_MINUS) || (c == CHAR_PLUS))) begin
               neg_in   = (c == CHAR_MINUS);
               phase_in = PH_SIGNED;
            end else if (c == CHAR_0) begin
               acc_in   = '0;
               phase_in = PH_ZERO;
            end else if (dd.ok) begin
               acc_in   = {{(RESULT_WIDTH-DIGIT_WIDTH){1'b0}}, dd.value};
               phase_in = PH_DEC;
            end else begin
               phase_in = PH_STOP;
            end
         end
         PH_ZERO: begin
            if ((c == CHAR_LX) || (c == CHAR_UX)) begin
               acc_in   = '0;
               phase_in = PH_HEX;
            end else if (dd.ok) begin
               acc_in   = acc_x10;
               phase_in = PH_DEC;
            end else begin
               phase_in = PH_STOP;
            end
         end
         PH_DEC: begin
            if (dd.ok) begin
               acc_in = acc_x10;
            end else begin
               phase_in = PH_STOP;
            end
         end
         PH_HEX: begin
            if (hd.ok) begin
               acc_in = acc_x16;
            end else begin
               phase_in = PH_STOP;
            end
         end
         PH_STOP: begin
            phase_in = PH_STOP;
         end
         default: begin
            phase_in = PH_STOP;
         end
      endcase
   end

   assign result_valid = take && item.end_of_string;
   assign result_value = neg_in ? ('0 - acc_in) : acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
      end else if (take) begin
         if (item.end_of_string) begin
            phase_ff <= PH_SPACE;
            acc_ff   <= '0;
            neg_ff   <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
         end
      end
   end

   `AIP_ASSERT(a_stop_holds, clock, reset, (take && !item.end_of_string && phase_ff == PH_STOP) |=> (phase_ff == PH_STOP), "Parser left the stopped phase before the end of the string.")
   `AIP_ASSERT(a_clear_after_end, clock, reset, result_valid |=> (phase_ff == PH_SPACE && acc_ff == '0 && !neg_ff), "Parser state was not cleared after the end of a string.")
   `AIP_ASSERT(a_acc_zero_early, clock, reset, (phase_ff == PH_SPACE || phase_ff == PH_SIGNED) |-> (acc_ff == '0), "Accumulator is not zero before the first digit.")

endmodule

// ===== hdl/ascii_integer_parser.sv =====
// Top level of the streaming ASCII to signed integer parser.
// The request channel carries one character word per cycle, req_char_code with
// req_end_of_string marking the last character of a string. The parser skips
// leading whitespace, takes one optional sign, reads decimal digits or, after
// a 0x or 0X prefix, hexadecimal digits, and stops at the first other character.
// The response channel carries one word, rsp_parsed_value, for each string,
// produced by the character flagged as end of string; other characters give none.
// A word passes an input register and then a result register: a result appears
// in the result register once its last character is taken from the input register.
// Throughput is one character per cycle while the request channel does not stall.
// While the receiver stalls a waiting result, characters without the end flag
// still flow; an end-flagged character waits in the input register and the
// request channel stalls until the result is taken.
// Synchronous reset clears the valid flags of both registers and returns the parser
// to skipping whitespace with a zero accumulator and a positive sign.
`include "assert_macros.svh"
module ascii_integer_parser
   import aip_pkg::*;
#(
   parameter int RESULT_WIDTH = RESULT_WIDTH_DEFAULT
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [CHAR_WIDTH-1:0]          req_char_code,
   input  logic                           req_end_of_string,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [RESULT_WIDTH-1:0] rsp_parsed_value
);

   item_type                item;
   logic                    advance;
   logic                    result_valid;
   logic [RESULT_WIDTH-1:0] result_value;
   logic                    rsp_valid_ff;
   logic [RESULT_WIDTH-1:0] rsp_value_ff;

   // Only an end-flagged word needs the result register to be free.
   assign advance = !(item.end_of_string && rsp_valid_ff && rsp_stall);

   aip_input_stage u_input (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .advance           (advance),
      .item              (item)
   );

   aip_core #(
      .RESULT_WIDTH (RESULT_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .item         (item),
      .advance      (advance),
      .result_valid (result_valid),
      .result_value (result_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         rsp_value_ff <= result_value;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parsed_value = $signed(rsp_value_ff);

   `AIP_ASSERT(a_no_overwrite, clock, reset, (rsp_valid_ff && rsp_stall) |-> !result_valid, "A waiting result would be overwritten.")
   `AIP_ASSERT(a_hold_stalled, clock, reset, (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_value_ff)), "A stalled result changed.")
   `AIP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid_ff, "Result register is not empty after reset.")

endmodule
